// ----- rtl/cst_pkg.sv -----
// Shared types and constants for the client session table.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Widths of the item fields.
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TOUT_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int MSG_W   = 2;
    localparam int MASK_W  = 10;

    // Timeout after reset, in seconds.
    localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 16'd10;

    // Result codes.
    typedef enum logic [1:0] {
        ACT_ACCEPTED = 2'd0,
        ACT_GOODBYE  = 2'd1,
        ACT_REFUSED  = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic              eval;
        logic              commit;
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
        logic [TOUT_W-1:0] timeout;
    } t_cmd;

    // Flags handed from one cell to the next, lowest slot first.
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_chain;

endpackage

`default_nettype wire

// ----- rtl/cst_cell.sv -----
// One session slot of the table with its compare logic and chain links.
`timescale 1ns / 1ps
`default_nettype none

module cst_cell
    import cst_pkg::*;
#(
    parameter int IW       = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic          i_any_hit,
    input  wire t_chain        i_chain,
    input  wire logic [IW-1:0] i_hit_idx,
    input  wire logic [IW-1:0] i_free_idx,
    output t_chain             o_chain,
    output logic      [IW-1:0] o_hit_idx,
    output logic      [IW-1:0] o_free_idx,
    output logic               o_sel,
    output logic               o_exp
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;
    logic [TIME_W-1:0] r_time;
    logic              r_hit;
    logic              r_free;
    logic              r_exp;
    logic [TIME_W-1:0] w_age;
    logic              w_sel_hit;
    logic              w_sel_free;

    // Compare stage: match, free and expiry flags from the stored entry.
    assign w_age = i_cmd.now - r_time;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_hit  <= r_valid && !i_cmd.op && (r_addr == i_cmd.addr)
                      && (r_port == i_cmd.port);
            r_free <= !r_valid && !i_cmd.op;
            r_exp  <= r_valid && i_cmd.op && (w_age >= TIME_W'(i_cmd.timeout));
        end
    end

    // Only the lowest matching slot, or failing that the lowest free one, is chosen.
    assign w_sel_hit  = r_hit && !i_chain.hit_seen;
    assign w_sel_free = r_free && !i_chain.free_seen && !i_any_hit;

    assign o_chain.hit_seen  = i_chain.hit_seen | r_hit;
    assign o_chain.free_seen = i_chain.free_seen | r_free;
    assign o_hit_idx  = w_sel_hit ? IW'(CELL_IDX) : i_hit_idx;
    assign o_free_idx = (r_free && !i_chain.free_seen) ? IW'(CELL_IDX) : i_free_idx;
    assign o_sel      = w_sel_hit | w_sel_free;
    assign o_exp      = r_exp;

    // Valid mark: cleared by goodbye or expiry, set by a new session.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            if (i_cmd.op) begin
                if (r_exp) begin
                    r_valid <= 1'b0;
                end
            end else if (w_sel_hit) begin
                r_valid <= 1'b0;
            end else if (w_sel_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Session contents are written only when the slot is allocated.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !i_cmd.op && w_sel_free) begin
            r_addr <= i_cmd.addr;
            r_port <= i_cmd.port;
            r_time <= i_cmd.now;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/client_session_table_with_timeout_top.sv -----
// Top level of the client session table with idle timeout.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready| tuser: operation; tdata: address,
//           |           |                              | port, current time
//  m_axis   | out       | m_axis_tvalid / m_axis_tready| tuser: action; tdata: slot,
//           |           |                              | message index, expired mask
//  cfg      | in        | i_cfg_valid / o_cfg_ready    | timeout in seconds
//
//  Each item passes through a compare state, in which every cell compares its entry
//  with the item, and then an update state, in which the chain of cells picks the lowest
//  slot and the table updates. A following item is taken in the same cycle as the update.
//  Reset clears all valid marks at once; no clearing pass is needed. While the result
//  register is full and not taken, the update cycle waits.
`timescale 1ns / 1ps
`default_nettype none

module client_session_table_with_timeout_top
    import cst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] source_address, [47:32] source_port, [79:48] current_time
    input  wire logic [79:0]               s_axis_tdata,
    // [0] operation
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [3:0] slot_index, [5:4] message_index, [15:6] expired_mask
    output logic [15:0]                    m_axis_tdata,
    // [1:0] action
    output logic [1:0]                     m_axis_tuser,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [TOUT_W-1:0]         i_cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;
    logic [TIME_W-1:0] r_now;
    logic [TOUT_W-1:0] r_timeout;
    logic              r_out_valid;
    t_action           r_out_action;
    logic [SLOT_W-1:0] r_out_slot;
    logic [MSG_W-1:0]  r_out_msg;
    logic [MASK_W-1:0] r_out_mask;

    logic              w_accept;
    logic              w_commit;
    t_cmd              w_cmd;
    t_chain            w_chain    [0:TABLE_ENTRIES];
    logic [IW-1:0]     w_hit_idx  [0:TABLE_ENTRIES];
    logic [IW-1:0]     w_free_idx [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_sel;
    logic [TABLE_ENTRIES-1:0] w_exp;
    logic              w_any_hit;
    logic              w_any_free;
    t_action           w_action;
    logic [SLOT_W-1:0] w_slot;

    // Handshakes: the update cycle waits for room in the result register.
    assign w_commit      = (r_state == ST_COMMIT) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == ST_IDLE) || w_commit;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_EVAL;
            ST_EVAL:   n_state = ST_COMMIT;
            ST_COMMIT: begin
                if (w_commit) begin
                    n_state = w_accept ? ST_EVAL : ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Item register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_addr <= s_axis_tdata[31:0];
            r_port <= s_axis_tdata[47:32];
            r_now  <= s_axis_tdata[79:48];
        end
    end

    // Command broadcast to the cells.
    always_comb begin
        w_cmd.eval    = (r_state == ST_EVAL);
        w_cmd.commit  = w_commit;
        w_cmd.op      = r_op;
        w_cmd.addr    = r_addr;
        w_cmd.port    = r_port;
        w_cmd.now     = r_now;
        w_cmd.timeout = r_timeout;
    end

    // Row of cells, slot 0 at the head of the chain.
    assign w_chain[0]    = '0;
    assign w_hit_idx[0]  = '0;
    assign w_free_idx[0] = '0;
    assign w_any_hit     = w_chain[TABLE_ENTRIES].hit_seen;
    assign w_any_free    = w_chain[TABLE_ENTRIES].free_seen;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        cst_cell #(
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_any_hit  (w_any_hit),
            .i_chain    (w_chain[g]),
            .i_hit_idx  (w_hit_idx[g]),
            .i_free_idx (w_free_idx[g]),
            .o_chain    (w_chain[g+1]),
            .o_hit_idx  (w_hit_idx[g+1]),
            .o_free_idx (w_free_idx[g+1]),
            .o_sel      (w_sel[g]),
            .o_exp      (w_exp[g])
        );
    end

    // Result of the item from the end of the chain.
    always_comb begin
        if (r_op) begin
            w_action = ACT_TICK;
            w_slot   = '0;
        end else if (w_any_hit) begin
            w_action = ACT_GOODBYE;
            w_slot   = SLOT_W'(w_hit_idx[TABLE_ENTRIES]);
        end else if (w_any_free) begin
            w_action = ACT_ACCEPTED;
            w_slot   = SLOT_W'(w_free_idx[TABLE_ENTRIES]);
        end else begin
            w_action = ACT_REFUSED;
            w_slot   = '0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_action <= w_action;
            r_out_slot   <= w_slot;
            r_out_msg    <= (w_action == ACT_ACCEPTED) ? w_slot[MSG_W-1:0] : '0;
            r_out_mask   <= r_op ? MASK_W'(w_exp) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {r_out_mask, r_out_msg, r_out_slot};

    // At most one slot is chosen in an update.
    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> $onehot0(w_sel))
        else $error("more than one slot chosen");

    // A finished update always leaves a result behind.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("result lost after update");

    // Tick results carry no slot or greeting.
    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action == ACT_TICK)) |-> (r_out_slot == '0 && r_out_msg == '0))
        else $error("tick result with slot or greeting");

    // Packet results carry no expiry mask.
    a_packet_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action != ACT_TICK)) |-> (r_out_mask == '0))
        else $error("packet result with expiry mask");

endmodule

`default_nettype wire
